// File: sv/ssgr_pkg.sv
// Package for the sorted-sequence gap reporter: payload structs, widths,
// register indexes and the controller/datapath handshake structs.
// No dependencies.
package ssgr_pkg;

  localparam int VALUE_W   = 16;
  localparam int LIMIT_W   = 7;
  localparam int EXPECT_W  = VALUE_W + 1;
  localparam int MAX_RUN_D = 64;

  // Configuration register indexes
  localparam logic REG_SINGLE_REPORT = 1'b0;
  localparam logic REG_RUN_LIMIT     = 1'b1;

  localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST = 7'd64;

  typedef struct packed {
    logic               start_of_sequence;
    logic [VALUE_W-1:0] value;
  } ssgr_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] missing_value;
    logic               last;
    logic               truncated;
  } ssgr_out_t;

  typedef struct packed {
    logic take;
    logic emit;
  } ssgr_cmd_t;

  typedef struct packed {
    logic run_pending;
    logic run_final;
  } ssgr_stat_t;

endpackage

// File: sv/ssgr_ctrl.sv
// Controller of the gap reporter: idle/emit state machine and the
// output valid flag. Depends on ssgr_pkg.
module ssgr_ctrl
  import ssgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ssgr_stat_t stat,
  output ssgr_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_IDLE);
  assign cmd.take = in_valid && in_ready;
  assign cmd.emit = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take && stat.run_pending) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit && stat.run_final) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // hold the result until taken
      if (cmd.emit)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/ssgr_datapath.sv
// Datapath of the gap reporter: configuration registers, expected value,
// run counter and output register. Depends on ssgr_pkg.
module ssgr_datapath
  import ssgr_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  ssgr_in_t           in_item,
  output ssgr_out_t          out_item,
  input  ssgr_cmd_t          cmd,
  output ssgr_stat_t         stat
);

  localparam logic [LIMIT_W-1:0] MAX_LIM = LIMIT_W'(MAX_RUN);
  localparam logic [EXPECT_W-1:0] EXPECT_TOP = EXPECT_W'(1) << VALUE_W;

  logic               single_report_mode;
  logic [LIMIT_W-1:0] run_limit;
  logic [EXPECT_W-1:0] expected_value;
  logic               already_reported;

  logic [VALUE_W-1:0] cur;
  logic [LIMIT_W-1:0] remaining;
  logic               trunc;

  logic [LIMIT_W-1:0]  lim;
  logic [EXPECT_W-1:0] value_ext;
  logic                above;
  logic [EXPECT_W-1:0] gap;
  logic                cut;
  logic [LIMIT_W-1:0]  cnt;
  logic [EXPECT_W-1:0] larger;
  logic [EXPECT_W:0]   bumped;
  logic [EXPECT_W-1:0] expected_next;

  always_comb begin
    if (run_limit == '0)         lim = LIMIT_W'(1);
    else if (run_limit > MAX_LIM) lim = MAX_LIM;
    else                          lim = run_limit;
  end

  assign value_ext = {1'b0, in_item.value};
  assign above     = value_ext > expected_value;
  assign gap       = value_ext - expected_value;
  assign cut       = gap > EXPECT_W'(lim);
  assign cnt       = cut ? lim : gap[LIMIT_W-1:0];
  assign larger    = above ? value_ext : expected_value;
  assign bumped    = {1'b0, larger} + (EXPECT_W+1)'(1);
  assign expected_next = (bumped > {1'b0, EXPECT_TOP}) ? EXPECT_TOP : bumped[EXPECT_W-1:0];

  assign stat.run_pending = !in_item.start_of_sequence && above
                            && (!single_report_mode || !already_reported);
  assign stat.run_final   = (remaining == LIMIT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      single_report_mode <= 1'b0;
      run_limit          <= RUN_LIMIT_RST;
      expected_value     <= '0;
      already_reported   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SINGLE_REPORT: single_report_mode <= cfg_wdata[0];
          REG_RUN_LIMIT:     run_limit          <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (in_item.start_of_sequence) begin
          expected_value   <= value_ext + EXPECT_W'(1);
          already_reported <= 1'b0;
        end else begin
          expected_value <= expected_next;
          if (above && single_report_mode) already_reported <= 1'b1;
        end
      end
    end
  end

  // run registers: load on take, advance on each emitted item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur <= expected_value[VALUE_W-1:0];
      if (single_report_mode) begin
        remaining <= LIMIT_W'(1);
        trunc     <= 1'b0;
      end else begin
        remaining <= cnt;
        trunc     <= cut;
      end
    end else if (cmd.emit) begin
      cur       <= cur + VALUE_W'(1);
      remaining <= remaining - LIMIT_W'(1);
    end
    if (cmd.emit) begin
      out_item.missing_value <= cur;
      out_item.last          <= stat.run_final;
      out_item.truncated     <= trunc;
    end
  end

endmodule

// File: sv/sorted_sequence_gap_reporter.sv
// Top level of the sorted-sequence gap reporter: joins controller and
// datapath. Depends on ssgr_pkg, ssgr_ctrl and ssgr_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries ascending values, each
//   new sequence opened by start_of_sequence. Output channel
//   (out_valid/out_ready/out_item) carries the skipped values ascending,
//   with last on the final item caused by one input and truncated on every
//   item of a run cut at run_limit; single_report_mode emits one per sequence.
//   Configuration: cfg_we with cfg_index selects single_report_mode (0) or
//   run_limit (1); write only while the block is idle.
// Timing:
//   An input that causes no result is taken while in_ready stays high.
//   An input that causes N results keeps in_ready low until the last of
//   them is loaded: the run counter in the datapath emits one missing
//   value per cycle into the output register unless out_ready stalls it.
//   A result passes the run registers and then the output register.
// Reset (rst, synchronous): expected value 0, single-report mode off,
//   run_limit 64, output register empty.
// Stall: while out_ready is low the output item is held and the run
//   pauses; a new input is still taken once the run is fully loaded.
module sorted_sequence_gap_reporter
  import ssgr_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssgr_in_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ssgr_out_t          out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  ssgr_cmd_t  cmd;
  ssgr_stat_t stat;

  // sequencing of accept, run and output register
  ssgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // expected value, run generation and configuration registers
  ssgr_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
